FILE: src/c65eu_pkg.sv
// Shared types and constants for the 6502 execute unit.
// No dependencies; imported by c65eu_alu and cpu6502_execute_unit.
package c65eu_pkg;

    typedef enum logic [5:0] {
        FN_LDA     = 6'd0,
        FN_LDX     = 6'd1,
        FN_LDY     = 6'd2,
        FN_STA     = 6'd3,
        FN_STX     = 6'd4,
        FN_STY     = 6'd5,
        FN_TAX     = 6'd6,
        FN_TAY     = 6'd7,
        FN_TSX     = 6'd8,
        FN_TXA     = 6'd9,
        FN_TXS     = 6'd10,
        FN_TYA     = 6'd11,
        FN_PHA     = 6'd12,
        FN_PHP     = 6'd13,
        FN_PLA     = 6'd14,
        FN_PLP     = 6'd15,
        FN_DEC     = 6'd16,
        FN_DEX     = 6'd17,
        FN_DEY     = 6'd18,
        FN_INC     = 6'd19,
        FN_INX     = 6'd20,
        FN_INY     = 6'd21,
        FN_ADC     = 6'd22,
        FN_SBC     = 6'd23,
        FN_AND     = 6'd24,
        FN_EOR     = 6'd25,
        FN_ORA     = 6'd26,
        FN_ASL_A   = 6'd27,
        FN_ASL_MEM = 6'd28,
        FN_LSR_A   = 6'd29,
        FN_LSR_MEM = 6'd30,
        FN_CLC     = 6'd31,
        FN_CLD     = 6'd32,
        FN_CLI     = 6'd33,
        FN_CLV     = 6'd34,
        FN_SEC     = 6'd35,
        FN_SED     = 6'd36,
        FN_SEI     = 6'd37,
        FN_CMP     = 6'd38,
        FN_CPX     = 6'd39,
        FN_CPY     = 6'd40,
        FN_BCC     = 6'd41,
        FN_BCS     = 6'd42,
        FN_BEQ     = 6'd43,
        FN_BMI     = 6'd44,
        FN_BNE     = 6'd45,
        FN_BPL     = 6'd46,
        FN_BVC     = 6'd47,
        FN_BVS     = 6'd48,
        FN_BRK     = 6'd49
    } func_t;

    // status bit positions, NV5BDIZC
    localparam int unsigned FLAG_C = 0;
    localparam int unsigned FLAG_Z = 1;
    localparam int unsigned FLAG_I = 2;
    localparam int unsigned FLAG_D = 3;
    localparam int unsigned FLAG_B = 4;
    localparam int unsigned FLAG_5 = 5;
    localparam int unsigned FLAG_V = 6;
    localparam int unsigned FLAG_N = 7;

    localparam logic [7:0] SP_RESET = 8'hFF;
    localparam logic [1:0] EXTRA_NONE  = 2'd0;
    localparam logic [1:0] EXTRA_TAKEN = 2'd1;
    localparam logic [1:0] EXTRA_PAGE  = 2'd2;

    typedef struct packed {
        logic [7:0] a;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] sp;
        logic [7:0] p;
        logic       halt;
    } arch_t;

    typedef struct packed {
        logic        wen;
        logic [7:0]  wdat;
        logic        wstk;
        logic [15:0] npc;
        logic [1:0]  extra;
    } exec_out_t;

endpackage

FILE: src/c65eu_alu.sv
// Combinational execute logic: next architectural state and side results.
// Depends on c65eu_pkg.
module c65eu_alu (
    input  c65eu_pkg::arch_t     cur,
    input  logic [5:0]           func,
    input  logic [7:0]           operand,
    input  logic [15:0]          pc,
    output c65eu_pkg::arch_t     nxt,
    output c65eu_pkg::exec_out_t res
);
    import c65eu_pkg::*;

    logic [7:0]  adc_m;
    logic [8:0]  adc_sum;
    logic [7:0]  adc_r;
    logic        adc_v;
    logic [7:0]  cmp_reg;
    logic [8:0]  cmp_diff;
    logic [7:0]  dec_m;
    logic [7:0]  inc_m;
    logic [15:0] br_target;
    logic        take;

    function automatic logic [7:0] set_nz(input logic [7:0] p, input logic [7:0] r);
        logic [7:0] q;
        q = p;
        q[FLAG_N] = r[7];
        q[FLAG_Z] = (r == 8'h00);
        return q;
    endfunction

    // SBC is ADC of the complemented operand
    assign adc_m   = (func == FN_SBC) ? ~operand : operand;
    assign adc_sum = {1'b0, cur.a} + {1'b0, adc_m} + {8'h00, cur.p[FLAG_C]};
    assign adc_r   = adc_sum[7:0];
    assign adc_v   = ~(cur.a[7] ^ adc_m[7]) & (cur.a[7] ^ adc_r[7]);

    assign cmp_reg  = (func == FN_CPX) ? cur.x : (func == FN_CPY) ? cur.y : cur.a;
    assign cmp_diff = {1'b0, cmp_reg} - {1'b0, operand};

    assign dec_m = operand - 8'd1;
    assign inc_m = operand + 8'd1;

    assign br_target = pc + {{8{operand[7]}}, operand};

    always_comb begin
        nxt       = cur;
        res.wen   = 1'b0;
        res.wdat  = 8'h00;
        res.wstk  = 1'b0;
        res.npc   = pc;
        res.extra = EXTRA_NONE;
        take      = 1'b0;
        if (!cur.halt) begin
            unique case (func_t'(func))
                FN_LDA: begin nxt.a = operand; nxt.p = set_nz(cur.p, operand); end
                FN_LDX: begin nxt.x = operand; nxt.p = set_nz(cur.p, operand); end
                FN_LDY: begin nxt.y = operand; nxt.p = set_nz(cur.p, operand); end
                FN_STA: begin res.wen = 1'b1; res.wdat = cur.a; end
                FN_STX: begin res.wen = 1'b1; res.wdat = cur.x; end
                FN_STY: begin res.wen = 1'b1; res.wdat = cur.y; end
                FN_TAX: begin nxt.x = cur.a; nxt.p = set_nz(cur.p, cur.a); end
                FN_TAY: begin nxt.y = cur.a; nxt.p = set_nz(cur.p, cur.a); end
                FN_TSX: begin nxt.x = cur.sp; nxt.p = set_nz(cur.p, cur.sp); end
                FN_TXA: begin nxt.a = cur.x; nxt.p = set_nz(cur.p, cur.x); end
                FN_TXS: nxt.sp = cur.x;
                FN_TYA: begin nxt.a = cur.y; nxt.p = set_nz(cur.p, cur.y); end
                FN_PHA: begin
                    res.wen  = 1'b1;
                    res.wstk = 1'b1;
                    res.wdat = cur.a;
                    nxt.sp   = cur.sp - 8'd1;
                end
                FN_PHP: begin
                    res.wen  = 1'b1;
                    res.wstk = 1'b1;
                    res.wdat = cur.p;
                    res.wdat[FLAG_B] = 1'b1;
                    res.wdat[FLAG_5] = 1'b1;
                    nxt.sp   = cur.sp - 8'd1;
                end
                FN_PLA: begin
                    nxt.sp = cur.sp + 8'd1;
                    nxt.a  = operand;
                    nxt.p  = set_nz(cur.p, operand);
                end
                FN_PLP: begin
                    nxt.sp = cur.sp + 8'd1;
                    nxt.p  = operand;
                end
                FN_DEC: begin res.wen = 1'b1; res.wdat = dec_m; nxt.p = set_nz(cur.p, dec_m); end
                FN_DEX: begin nxt.x = cur.x - 8'd1; nxt.p = set_nz(cur.p, cur.x - 8'd1); end
                FN_DEY: begin nxt.y = cur.y - 8'd1; nxt.p = set_nz(cur.p, cur.y - 8'd1); end
                FN_INC: begin res.wen = 1'b1; res.wdat = inc_m; nxt.p = set_nz(cur.p, inc_m); end
                FN_INX: begin nxt.x = cur.x + 8'd1; nxt.p = set_nz(cur.p, cur.x + 8'd1); end
                FN_INY: begin nxt.y = cur.y + 8'd1; nxt.p = set_nz(cur.p, cur.y + 8'd1); end
                FN_ADC, FN_SBC: begin
                    nxt.a = adc_r;
                    nxt.p = set_nz(cur.p, adc_r);
                    nxt.p[FLAG_C] = adc_sum[8];
                    nxt.p[FLAG_V] = adc_v;
                end
                FN_AND: begin nxt.a = cur.a & operand; nxt.p = set_nz(cur.p, cur.a & operand); end
                FN_EOR: begin nxt.a = cur.a ^ operand; nxt.p = set_nz(cur.p, cur.a ^ operand); end
                FN_ORA: begin nxt.a = cur.a | operand; nxt.p = set_nz(cur.p, cur.a | operand); end
                FN_ASL_A: begin
                    nxt.a = {cur.a[6:0], 1'b0};
                    nxt.p = set_nz(cur.p, {cur.a[6:0], 1'b0});
                    nxt.p[FLAG_C] = cur.a[7];
                end
                FN_ASL_MEM: begin
                    res.wen  = 1'b1;
                    res.wdat = {operand[6:0], 1'b0};
                    nxt.p = set_nz(cur.p, {operand[6:0], 1'b0});
                    nxt.p[FLAG_C] = operand[7];
                end
                FN_LSR_A: begin
                    nxt.a = {1'b0, cur.a[7:1]};
                    nxt.p = set_nz(cur.p, {1'b0, cur.a[7:1]});
                    nxt.p[FLAG_C] = cur.a[0];
                end
                FN_LSR_MEM: begin
                    res.wen  = 1'b1;
                    res.wdat = {1'b0, operand[7:1]};
                    nxt.p = set_nz(cur.p, {1'b0, operand[7:1]});
                    nxt.p[FLAG_C] = operand[0];
                end
                FN_CLC: nxt.p[FLAG_C] = 1'b0;
                FN_CLD: nxt.p[FLAG_D] = 1'b0;
                FN_CLI: nxt.p[FLAG_I] = 1'b0;
                FN_CLV: nxt.p[FLAG_V] = 1'b0;
                FN_SEC: nxt.p[FLAG_C] = 1'b1;
                FN_SED: nxt.p[FLAG_D] = 1'b1;
                FN_SEI: nxt.p[FLAG_I] = 1'b1;
                FN_CMP, FN_CPX, FN_CPY: begin
                    nxt.p[FLAG_C] = ~cmp_diff[8];
                    nxt.p[FLAG_Z] = (cmp_reg == operand);
                    nxt.p[FLAG_N] = cmp_diff[7];
                end
                FN_BCC: take = ~cur.p[FLAG_C];
                FN_BCS: take =  cur.p[FLAG_C];
                FN_BEQ: take =  cur.p[FLAG_Z];
                FN_BMI: take =  cur.p[FLAG_N];
                FN_BNE: take = ~cur.p[FLAG_Z];
                FN_BPL: take = ~cur.p[FLAG_N];
                FN_BVC: take = ~cur.p[FLAG_V];
                FN_BVS: take =  cur.p[FLAG_V];
                FN_BRK: nxt.halt = 1'b1;
                default: ;
            endcase
            if (take) begin
                res.npc   = br_target;
                res.extra = (br_target[15:8] != pc[15:8]) ? EXTRA_PAGE : EXTRA_TAKEN;
            end
        end
    end

endmodule

FILE: src/cpu6502_execute_unit.sv
// 6502 execute unit top level: input word register, architectural state,
// result register. Depends on c65eu_pkg and c65eu_alu.
//
// Takes one decoded instruction word per cycle while the result side is not
// stalled and returns one result word per instruction. The result word is
// held in the result register and can be taken when the output is not
// stalled. An accepted word sits in the input register; the execute logic
// works from it and the architectural registers (A, X, Y, SP, P, halt), and
// both the result register and the architectural registers load on the same
// edge, so a dependent instruction in the input register sees the updated
// state on the next cycle. Sustained rate is one word per cycle; a stall on
// the result side backs up through the two registers. BRK sets a sticky halt
// after which instructions report state unchanged; only reset clears it.
module cpu6502_execute_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [5:0]  s_func,
    input  logic [7:0]  s_operand,
    input  logic [15:0] s_pc,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_acc,
    output logic [7:0]  m_index_x,
    output logic [7:0]  m_index_y,
    output logic [7:0]  m_stack_ptr,
    output logic [7:0]  m_status,
    output logic        m_write_en,
    output logic [7:0]  m_write_data,
    output logic        m_write_to_stack,
    output logic [15:0] m_next_pc,
    output logic [1:0]  m_extra_cycles,
    output logic        m_halted
);
    import c65eu_pkg::*;

    logic        in_valid_reg;
    logic [5:0]  func_reg;
    logic [7:0]  operand_reg;
    logic [15:0] pc_reg;

    arch_t       arch_reg;
    arch_t       arch_next;
    exec_out_t   exec_res;

    logic        out_valid_reg;
    arch_t       out_arch_reg;
    exec_out_t   out_res_reg;

    logic        advance;
    logic        s_take;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign s_take  = s_valid && s_ready;

    c65eu_alu u_alu (
        .cur     (arch_reg),
        .func    (func_reg),
        .operand (operand_reg),
        .pc      (pc_reg),
        .nxt     (arch_next),
        .res     (exec_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            arch_reg.a    <= 8'h00;
            arch_reg.x    <= 8'h00;
            arch_reg.y    <= 8'h00;
            arch_reg.sp   <= SP_RESET;
            arch_reg.p    <= 8'h00;
            arch_reg.halt <= 1'b0;
        end else begin
            if (s_take) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                arch_reg      <= arch_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            func_reg    <= s_func;
            operand_reg <= s_operand;
            pc_reg      <= s_pc;
        end
        if (advance) begin
            out_arch_reg <= arch_next;
            out_res_reg  <= exec_res;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_acc            = out_arch_reg.a;
    assign m_index_x        = out_arch_reg.x;
    assign m_index_y        = out_arch_reg.y;
    assign m_stack_ptr      = out_arch_reg.sp;
    assign m_status         = out_arch_reg.p;
    assign m_halted         = out_arch_reg.halt;
    assign m_write_en       = out_res_reg.wen;
    assign m_write_data     = out_res_reg.wdat;
    assign m_write_to_stack = out_res_reg.wstk;
    assign m_next_pc        = out_res_reg.npc;
    assign m_extra_cycles   = out_res_reg.extra;

    // halt is sticky until reset
    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        arch_reg.halt |=> arch_reg.halt)
        else $error("halt mark cleared without reset");

    // a halted core issues no write and no branch
    a_halted_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && arch_reg.halt |=> !m_write_en && (m_extra_cycles == EXTRA_NONE))
        else $error("halted instruction produced a side effect");

    // stack writes are a subset of writes
    a_stack_write: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_write_to_stack |-> m_write_en)
        else $error("stack write flagged without write enable");

    // architectural state moves only when an instruction retires into the result register
    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(arch_reg))
        else $error("architectural state changed without a retiring word");

endmodule
